// ----- rtl/core/dfr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dfr_pkg;

    localparam int unsigned LENGTH_BITS_DEFAULT = 16;
    localparam int unsigned CFG_BITS            = 16;
    localparam int unsigned LEN_OUT_BITS        = 16;
    localparam int unsigned SEQ_BITS            = 9;

    localparam logic [CFG_BITS-1:0] MAX_BYTES_RESET = 16'hFFFF;

    localparam logic [7:0] TYPE_FIRST = 8'hF1;
    localparam logic [7:0] TYPE_NEXT  = 8'hF2;

    localparam logic [SEQ_BITS-1:0] SEQ_START = 9'd1;
    localparam logic [SEQ_BITS-1:0] SEQ_AFTER_FIRST = 9'd2;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_RESTART  = 3'd1,
        EV_COMPLETE = 3'd2,
        EV_SHORT    = 3'd3,
        EV_BADSEQ   = 3'd4,
        EV_BADTYPE  = 3'd5,
        EV_OVERFLOW = 3'd6
    } t_event;

    typedef enum logic [3:0] {
        PH_TYPE    = 4'b0001,
        PH_SEQ     = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_SKIP    = 4'b1000
    } t_phase;

endpackage

`default_nettype wire

// ----- rtl/core/datagram_fragment_reassembler.sv -----
// Datagram fragment reassembler.
// Input channel: one datagram byte per transfer on i_valid / o_ready, with
// markers for the first and last byte of each datagram. Output channel: at
// most one result per input byte on o_valid / i_ready, carrying a payload
// byte, its valid flag, an event code and the message length so far.
// Every datagram begins with a type byte and a sequence byte; only payload
// bytes and the restart, complete and error events produce a result.
// The capacity register is written through i_cfg_we / i_cfg_data. The user
// must write it while no transfer is in flight; the block does not enforce it.
// A byte goes through an input register and then a result register, which
// offers its result. One byte is taken per cycle unless the receiver
// stalls: then the result register holds and the input register fills,
// after which o_ready drops until the result is taken.
// Reset clears both stages, returns the parser to the type byte, clears
// the message state and sets the capacity to 65535.
`timescale 1ns / 1ps
`default_nettype none

module datagram_fragment_reassembler #(
    parameter int unsigned LENGTH_BITS = dfr_pkg::LENGTH_BITS_DEFAULT
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [dfr_pkg::CFG_BITS-1:0]  i_cfg_data,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [7:0]                    i_data_byte,
    input  wire logic                          i_first_of_datagram,
    input  wire logic                          i_last_of_datagram,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [7:0]                         o_payload_byte,
    output logic                               o_byte_valid,
    output logic [2:0]                         o_event_res,
    output logic [dfr_pkg::LEN_OUT_BITS-1:0]   o_message_length
);
    import dfr_pkg::*;

    localparam int unsigned CW = (LENGTH_BITS > CFG_BITS) ? LENGTH_BITS : CFG_BITS;
    localparam int unsigned LW = (LENGTH_BITS > LEN_OUT_BITS) ? LENGTH_BITS : LEN_OUT_BITS;

    logic [CFG_BITS-1:0]    r_max_bytes;

    logic                   r_s1_valid;
    logic [7:0]             r_s1_byte;
    logic                   r_s1_first;
    logic                   r_s1_last;

    t_phase                 r_phase;
    logic                   r_frag_first;
    logic [SEQ_BITS-1:0]    r_exp_seq;
    logic [7:0]             r_final_seq;
    logic [LENGTH_BITS-1:0] r_gathered;

    logic                   r_out_valid;
    logic [7:0]             r_out_byte;
    logic                   r_out_bvalid;
    t_event                 r_out_event;
    logic [LEN_OUT_BITS-1:0] r_out_len;

    t_phase                 n_phase;
    logic                   n_frag_first;
    logic [SEQ_BITS-1:0]    n_exp_seq;
    logic [7:0]             n_final_seq;
    logic [LENGTH_BITS-1:0] n_gathered;

    logic                   res_en;
    logic [7:0]             res_byte;
    logic                   res_bvalid;
    t_event                 res_event;
    logic [LENGTH_BITS-1:0] res_len;
    logic [LW-1:0]          res_len_ext;

    t_phase                 cur_phase;
    logic                   advance;
    logic [CW-1:0]          cap_cfg;
    logic [CW-1:0]          cap_lim;
    logic [CW-1:0]          capacity;
    logic [CW-1:0]          gathered_ext;
    logic                   at_capacity;
    logic                   final_match;
    logic                   seq_match;
    logic [LENGTH_BITS-1:0] gathered_inc;

    assign advance = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_s1_valid || advance;

    assign cap_cfg      = CW'(r_max_bytes);
    assign cap_lim      = CW'({LENGTH_BITS{1'b1}});
    assign capacity     = (cap_cfg < cap_lim) ? cap_cfg : cap_lim;
    assign gathered_ext = CW'(r_gathered);
    assign at_capacity  = gathered_ext >= capacity;
    assign final_match  = {1'b0, r_final_seq} == r_exp_seq;
    assign seq_match    = {1'b0, r_s1_byte} == r_exp_seq;
    assign gathered_inc = r_gathered + LENGTH_BITS'(1);
    assign res_len_ext  = LW'(res_len);

    always_comb begin
        cur_phase    = r_s1_first ? PH_TYPE : r_phase;
        n_phase      = cur_phase;
        n_frag_first = r_frag_first;
        n_exp_seq    = r_exp_seq;
        n_final_seq  = r_final_seq;
        n_gathered   = r_gathered;
        res_en       = 1'b0;
        res_byte     = 8'd0;
        res_bvalid   = 1'b0;
        res_event    = EV_NONE;
        res_len      = r_gathered;
        case (cur_phase)
            PH_TYPE: begin
                if (r_s1_last) begin
                    res_en    = 1'b1;
                    res_event = EV_SHORT;
                    n_phase   = PH_TYPE;
                end else if (r_s1_byte == TYPE_FIRST || r_s1_byte == TYPE_NEXT) begin
                    n_frag_first = (r_s1_byte == TYPE_FIRST);
                    n_phase      = PH_SEQ;
                end else begin
                    res_en    = 1'b1;
                    res_event = EV_BADTYPE;
                    n_phase   = PH_SKIP;
                end
            end
            PH_SEQ: begin
                if (r_frag_first) begin
                    res_en       = 1'b1;
                    res_event    = EV_RESTART;
                    res_len      = '0;
                    n_frag_first = 1'b1;
                    n_final_seq  = r_s1_byte;
                    n_exp_seq    = SEQ_AFTER_FIRST;
                    n_gathered   = '0;
                    n_phase      = r_s1_last ? PH_TYPE : PH_PAYLOAD;
                end else if (!seq_match) begin
                    res_en    = 1'b1;
                    res_event = EV_BADSEQ;
                    n_phase   = r_s1_last ? PH_TYPE : PH_SKIP;
                end else if (!r_s1_last) begin
                    n_phase = PH_PAYLOAD;
                end else begin
                    n_phase = PH_TYPE;
                    if (final_match) begin
                        res_en    = 1'b1;
                        res_event = EV_COMPLETE;
                    end else begin
                        n_exp_seq = r_exp_seq + SEQ_BITS'(1);
                    end
                end
            end
            PH_PAYLOAD: begin
                res_en = 1'b1;
                if (at_capacity) begin
                    res_event = EV_OVERFLOW;
                    n_phase   = r_s1_last ? PH_TYPE : PH_SKIP;
                end else begin
                    res_byte   = r_s1_byte;
                    res_bvalid = 1'b1;
                    res_len    = gathered_inc;
                    n_gathered = gathered_inc;
                    if (r_s1_last) begin
                        n_phase = PH_TYPE;
                        if (!r_frag_first) begin
                            if (final_match) begin
                                res_event = EV_COMPLETE;
                            end else begin
                                n_exp_seq = r_exp_seq + SEQ_BITS'(1);
                            end
                        end
                    end
                end
            end
            PH_SKIP: begin
                if (r_s1_last) begin
                    n_phase = PH_TYPE;
                end
            end
            default: begin
                n_phase = PH_TYPE;
            end
        endcase
        // Every event except restart ends the message and clears its state.
        if (res_en && res_event != EV_NONE && res_event != EV_RESTART) begin
            n_frag_first = 1'b0;
            n_exp_seq    = SEQ_START;
            n_final_seq  = 8'd0;
            n_gathered   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_bytes <= MAX_BYTES_RESET;
        end else if (i_cfg_we) begin
            r_max_bytes <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_s1_byte  <= i_data_byte;
            r_s1_first <= i_first_of_datagram;
            r_s1_last  <= i_last_of_datagram;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_TYPE;
            r_frag_first <= 1'b0;
            r_exp_seq    <= SEQ_START;
            r_final_seq  <= 8'd0;
            r_gathered   <= '0;
        end else if (advance) begin
            r_phase      <= n_phase;
            r_frag_first <= n_frag_first;
            r_exp_seq    <= n_exp_seq;
            r_final_seq  <= n_final_seq;
            r_gathered   <= n_gathered;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && res_en) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_en) begin
            r_out_byte   <= res_byte;
            r_out_bvalid <= res_bvalid;
            r_out_event  <= res_event;
            r_out_len    <= res_len_ext[LEN_OUT_BITS-1:0];
        end
    end

    assign o_valid          = r_out_valid;
    assign o_payload_byte   = r_out_byte;
    assign o_byte_valid     = r_out_bvalid;
    assign o_event_res      = r_out_event;
    assign o_message_length = r_out_len;

`ifndef SYNTHESIS
    a_data_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_byte_valid) |->
            (o_event_res == EV_NONE || o_event_res == EV_COMPLETE))
        else $error("Payload byte carries an error or restart event.");

    a_no_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_byte_valid) |-> (o_payload_byte == 8'd0))
        else $error("Payload byte is not zero on an event-only result.");

    a_restart_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_event_res == EV_RESTART) |-> (o_message_length == '0))
        else $error("Restart reports a nonzero message length.");
`endif

endmodule

`default_nettype wire

// ----- bench/tb_datagram_fragment_reassembler.sv -----
`timescale 1ns / 1ps

module tb_datagram_fragment_reassembler;

    import dfr_pkg::*;

    localparam int unsigned HOLD_CYCLES    = 80;
    localparam int unsigned DRAIN_CYCLES   = 4;
    localparam int unsigned TAIL_CYCLES    = 8;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned RESULTS_PER_PHASE = 28;

    typedef struct packed {
        logic [7:0]  payload;
        logic        byte_ok;
        t_event      ev;
        logic [15:0] length;
    } reasm_out_t;

    typedef enum {ROW_PRED, ROW_TYPED, ROW_QUIET, ROW_CFG} row_kind_t;
    typedef enum {RX_OPEN, RX_RANDOM, RX_PATTERN, RX_SPARSE} rx_mode_t;

    typedef struct {
        row_kind_t   kind;
        logic [15:0] value;
        bit          is_first;
        bit          is_last;
        reasm_out_t  want;
    } row_t;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte = '0;
    logic        i_first_of_datagram = 1'b0;
    logic        i_last_of_datagram = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_payload_byte;
    logic        o_byte_valid;
    logic [2:0]  o_event_res;
    logic [15:0] o_message_length;

    datagram_fragment_reassembler u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_data          (i_cfg_data),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_data_byte         (i_data_byte),
        .i_first_of_datagram (i_first_of_datagram),
        .i_last_of_datagram  (i_last_of_datagram),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_payload_byte      (o_payload_byte),
        .o_byte_valid        (o_byte_valid),
        .o_event_res         (o_event_res),
        .o_message_length    (o_message_length)
    );

    // Reassembly state as the block should hold it.
    t_phase      ph = PH_TYPE;
    bit          frag_first = 1'b0;
    logic [8:0]  exp_seq = SEQ_START;
    logic [7:0]  fin_seq = 8'd0;
    logic [15:0] gathered = 16'd0;
    logic [15:0] cap_bytes = MAX_BYTES_RESET;

    reasm_out_t  reasm_expected[$];
    row_t        directed_rows[$];
    logic [7:0]  dgram[$];
    int unsigned results_made = 0;
    int unsigned mismatches = 0;
    int unsigned burst_left = 1;
    logic        hold_req = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic void clear_message_state();
        exp_seq = SEQ_START;
        fin_seq = 8'd0;
        gathered = 16'd0;
        frag_first = 1'b0;
    endfunction

    function automatic reasm_out_t abort_message(input t_event ev, input bit is_last);
        reasm_out_t res;
        res = '{8'h00, 1'b0, ev, gathered};
        clear_message_state();
        ph = is_last ? PH_TYPE : PH_SKIP;
        return res;
    endfunction

    function automatic bit reassemble_byte(input logic [7:0] b, input bit is_first,
                                           input bit is_last, output reasm_out_t res);
        logic [15:0] len;
        t_event      ev;
        res = '0;
        if (is_first) begin
            ph = PH_TYPE;
        end
        case (ph)
            PH_TYPE: begin
                if (is_last) begin
                    res = abort_message(EV_SHORT, 1'b1);
                    return 1'b1;
                end
                if (b == TYPE_FIRST || b == TYPE_NEXT) begin
                    frag_first = (b == TYPE_FIRST);
                    ph = PH_SEQ;
                    return 1'b0;
                end
                res = abort_message(EV_BADTYPE, 1'b0);
                return 1'b1;
            end
            PH_SEQ: begin
                if (frag_first) begin
                    clear_message_state();
                    frag_first = 1'b1;
                    fin_seq = b;
                    exp_seq = SEQ_AFTER_FIRST;
                    ph = is_last ? PH_TYPE : PH_PAYLOAD;
                    res = '{8'h00, 1'b0, EV_RESTART, 16'd0};
                    return 1'b1;
                end
                if ({1'b0, b} != exp_seq) begin
                    res = abort_message(EV_BADSEQ, is_last);
                    return 1'b1;
                end
                if (!is_last) begin
                    ph = PH_PAYLOAD;
                    return 1'b0;
                end
                ph = PH_TYPE;
                if ({1'b0, fin_seq} == exp_seq) begin
                    len = gathered;
                    clear_message_state();
                    res = '{8'h00, 1'b0, EV_COMPLETE, len};
                    return 1'b1;
                end
                exp_seq = exp_seq + 9'd1;
                return 1'b0;
            end
            PH_PAYLOAD: begin
                if (gathered >= cap_bytes) begin
                    res = abort_message(EV_OVERFLOW, is_last);
                    return 1'b1;
                end
                gathered = gathered + 16'd1;
                len = gathered;
                ev = EV_NONE;
                if (is_last) begin
                    ph = PH_TYPE;
                    if (!frag_first) begin
                        if ({1'b0, fin_seq} == exp_seq) begin
                            ev = EV_COMPLETE;
                            clear_message_state();
                        end else begin
                            exp_seq = exp_seq + 9'd1;
                        end
                    end
                end
                res = '{b, 1'b1, ev, len};
                return 1'b1;
            end
            default: begin
                if (is_last) begin
                    ph = PH_TYPE;
                end
                return 1'b0;
            end
        endcase
    endfunction

    function automatic row_t mk_row(input row_kind_t kind, input logic [15:0] value,
                                    input bit is_first, input bit is_last,
                                    input t_event ev, input logic [15:0] len);
        row_t r;
        r.kind = kind;
        r.value = value;
        r.is_first = is_first;
        r.is_last = is_last;
        r.want = '{8'h00, 1'b0, ev, len};
        return r;
    endfunction

    task automatic send_item(input logic [7:0] b, input bit is_first, input bit is_last,
                             input row_kind_t kind, input reasm_out_t want);
        reasm_out_t res;
        bit         has;
        i_valid <= 1'b1;
        i_data_byte <= b;
        i_first_of_datagram <= is_first;
        i_last_of_datagram <= is_last;
        do @(posedge i_clk); while (!o_ready);
        has = reassemble_byte(b, is_first, is_last, res);
        if (kind == ROW_TYPED) begin
            reasm_expected.push_back(want);
        end else if (kind == ROW_PRED && has) begin
            reasm_expected.push_back(res);
        end
        if (has) begin
            results_made++;
        end
    endtask

    // Bursts of random length, mostly short, sometimes long stretches with no gaps.
    task automatic sender_idle();
        if (burst_left > 0) begin
            burst_left--;
        end
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 10);
        end
    endtask

    task automatic write_capacity(input logic [15:0] value);
        i_valid <= 1'b0;
        while (reasm_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cap_bytes = value;
    endtask

    task automatic send_datagram(input bit mark_first, input bit cut);
        for (int i = 0; i < dgram.size(); i++) begin
            send_item(dgram[i], mark_first && i == 0, !cut && i == dgram.size() - 1,
                      ROW_PRED, '0);
            sender_idle();
        end
    endtask

    task automatic send_random_traffic();
        int unsigned fin;
        int unsigned frags;
        int unsigned seq;
        int unsigned k;
        dgram.delete();
        if ($urandom_range(0, 99) < 75) begin
            fin = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(2, 5);
            frags = (fin >= 2 && fin <= 5) ? fin : $urandom_range(1, 3);
            for (int f = 1; f <= frags; f++) begin
                dgram.delete();
                dgram.push_back(f == 1 ? TYPE_FIRST : TYPE_NEXT);
                seq = (f == 1) ? fin : f;
                if (f > 1 && $urandom_range(0, 11) == 0) begin
                    seq = $urandom_range(0, 255);
                end
                dgram.push_back(8'(seq));
                k = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 5);
                repeat (k) dgram.push_back(8'($urandom));
                send_datagram(1'b1, 1'b0);
            end
        end else begin
            case ($urandom_range(0, 2))
                0: dgram.push_back(TYPE_FIRST);
                1: dgram.push_back(TYPE_NEXT);
                default: dgram.push_back(8'($urandom));
            endcase
            repeat ($urandom_range(0, 6)) dgram.push_back(8'($urandom));
            send_datagram($urandom_range(0, 3) != 0, $urandom_range(0, 3) == 0);
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        reasm_out_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (reasm_expected.size() == 0) begin
                $display("%0t: unexpected result payload %0d valid %0d event %0d length %0d",
                         $time, o_payload_byte, o_byte_valid, o_event_res, o_message_length);
                mismatches++;
            end else begin
                want = reasm_expected.pop_front();
                check_field("payload_byte", want.payload, o_payload_byte);
                check_field("byte_valid", want.byte_ok, o_byte_valid);
                check_field("event_res", want.ev, o_event_res);
                check_field("message_length", want.length, o_message_length);
            end
        end
    end

    initial begin : receiver
        rx_mode_t    mode;
        int unsigned mode_left;
        int unsigned rx_count;
        bit          hold_done;
        mode = RX_OPEN;
        mode_left = 0;
        rx_count = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(8, 60);
                end
                mode_left--;
                rx_count++;
                case (mode)
                    RX_OPEN:    i_ready <= 1'b1;
                    RX_RANDOM:  i_ready <= ($urandom_range(0, 3) != 0);
                    RX_PATTERN: i_ready <= ((rx_count % 7) < 4);
                    default:    i_ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("[datagram_fragment_reassembler] ERROR");
        $finish;
    end

    initial begin : stimulus
        logic [15:0] caps[$];
        int unsigned target;

        directed_rows.push_back(mk_row(ROW_TYPED, 16'h00, 1, 1, EV_SHORT, 0));
        directed_rows.push_back(mk_row(ROW_TYPED, 16'hFF, 1, 0, EV_BADTYPE, 0));
        directed_rows.push_back(mk_row(ROW_QUIET, 16'h55, 0, 1, EV_NONE, 0));
        // A following fragment with no first fragment before it.
        directed_rows.push_back(mk_row(ROW_QUIET, TYPE_NEXT, 1, 0, EV_NONE, 0));
        directed_rows.push_back(mk_row(ROW_PRED, 16'h01, 0, 0, EV_NONE, 0));
        directed_rows.push_back(mk_row(ROW_PRED, 16'hFF, 0, 1, EV_NONE, 0));
        // A first fragment on its own never completes.
        directed_rows.push_back(mk_row(ROW_QUIET, TYPE_FIRST, 1, 0, EV_NONE, 0));
        directed_rows.push_back(mk_row(ROW_TYPED, 16'h03, 0, 0, EV_RESTART, 0));
        directed_rows.push_back(mk_row(ROW_PRED, 16'h80, 0, 1, EV_NONE, 0));
        directed_rows.push_back(mk_row(ROW_QUIET, TYPE_NEXT, 1, 0, EV_NONE, 0));
        directed_rows.push_back(mk_row(ROW_PRED, 16'h02, 0, 1, EV_NONE, 0));
        directed_rows.push_back(mk_row(ROW_QUIET, TYPE_NEXT, 1, 0, EV_NONE, 0));
        directed_rows.push_back(mk_row(ROW_PRED, 16'h03, 0, 0, EV_NONE, 0));
        directed_rows.push_back(mk_row(ROW_PRED, 16'h7F, 0, 1, EV_NONE, 0));
        directed_rows.push_back(mk_row(ROW_QUIET, TYPE_NEXT, 1, 0, EV_NONE, 0));
        directed_rows.push_back(mk_row(ROW_TYPED, 16'h05, 0, 1, EV_BADSEQ, 0));
        directed_rows.push_back(mk_row(ROW_QUIET, TYPE_FIRST, 1, 0, EV_NONE, 0));
        directed_rows.push_back(mk_row(ROW_TYPED, 16'h02, 0, 0, EV_RESTART, 0));
        directed_rows.push_back(mk_row(ROW_PRED, 16'h11, 0, 0, EV_NONE, 0));
        // A new first marker drops the open datagram; the empty fragment then completes.
        directed_rows.push_back(mk_row(ROW_QUIET, TYPE_NEXT, 1, 0, EV_NONE, 0));
        directed_rows.push_back(mk_row(ROW_PRED, 16'h02, 0, 1, EV_NONE, 0));
        // A type byte that lacks its first marker is still taken as a type byte.
        directed_rows.push_back(mk_row(ROW_QUIET, TYPE_FIRST, 0, 0, EV_NONE, 0));
        directed_rows.push_back(mk_row(ROW_TYPED, 16'h09, 0, 1, EV_RESTART, 0));
        directed_rows.push_back(mk_row(ROW_CFG, 16'd1, 0, 0, EV_NONE, 0));
        directed_rows.push_back(mk_row(ROW_QUIET, TYPE_FIRST, 1, 0, EV_NONE, 0));
        directed_rows.push_back(mk_row(ROW_TYPED, 16'h05, 0, 0, EV_RESTART, 0));
        directed_rows.push_back(mk_row(ROW_PRED, 16'hAA, 0, 0, EV_NONE, 0));
        directed_rows.push_back(mk_row(ROW_TYPED, 16'hBB, 0, 0, EV_OVERFLOW, 1));
        directed_rows.push_back(mk_row(ROW_QUIET, 16'hCC, 0, 1, EV_NONE, 0));
        directed_rows.push_back(mk_row(ROW_CFG, 16'd0, 0, 0, EV_NONE, 0));
        directed_rows.push_back(mk_row(ROW_QUIET, TYPE_FIRST, 1, 0, EV_NONE, 0));
        directed_rows.push_back(mk_row(ROW_TYPED, 16'h02, 0, 0, EV_RESTART, 0));
        directed_rows.push_back(mk_row(ROW_TYPED, 16'h44, 0, 1, EV_OVERFLOW, 0));

        caps = '{16'hFFFF, 16'd5, 16'd1, 16'd0, 16'($urandom_range(2, 40)), 16'hFFFF};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                write_capacity(directed_rows[i].value);
            end else begin
                send_item(directed_rows[i].value[7:0], directed_rows[i].is_first,
                          directed_rows[i].is_last, directed_rows[i].kind,
                          directed_rows[i].want);
                sender_idle();
            end
        end

        foreach (caps[p]) begin
            write_capacity(caps[p]);
            if (p == 0) begin
                hold_req <= 1'b1;
            end
            target = results_made + RESULTS_PER_PHASE;
            while (results_made < target) begin
                send_random_traffic();
            end
        end

        i_valid <= 1'b0;
        while (reasm_expected.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && reasm_expected.size() == 0) begin
            $display("[datagram_fragment_reassembler] OK");
        end else begin
            $display("[datagram_fragment_reassembler] ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/dfr_pkg.sv
rtl/core/datagram_fragment_reassembler.sv
bench/tb_datagram_fragment_reassembler.sv
